// ===== src/swk_pkg.sv =====
// shared constants, types and angle table for the swerve wheel kinematics block
package swk_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ANGLE_BITS    = 13;
    localparam int TABLE_LEN     = 24;
    localparam int NUM_STAGES    = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

    localparam int VEL_W   = 16;
    localparam int LEN_W   = 11;
    localparam int SCALE_W = 24;
    localparam int CFG_W   = 24;
    localparam int PROD_W  = 28;
    localparam int ROT_W   = 17;
    localparam int VEC_W   = 18;
    localparam int CORD_W  = 29;
    localparam int FRAC_BITS = 8;
    localparam int GAIN_W  = 16;
    localparam int MAG_W   = 28;
    localparam int RPM_W   = 16;
    localparam int HEAD_W  = 13;
    localparam int NUM_WHEELS = 4;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 120;

    localparam logic [GAIN_W-1:0] INV_GAIN_Q16 = 16'd39797;
    localparam logic [31:0] HALF_TURN  = 32'h8000_0000;
    localparam logic [31:0] HEAD_ROUND = 32'd1 << (31 - ANGLE_BITS);

    typedef enum logic [1:0] {
        REG_HALF_LENGTH_A = 2'd0,
        REG_HALF_WIDTH_B  = 2'd1,
        REG_SPEED_SCALE   = 2'd2,
        REG_UNUSED        = 2'd3
    } cfg_index_t;

    typedef logic signed [CORD_W-1:0] cord_t;

    // atan(2^-i) as a fraction of a full turn, 2^32 per turn
    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] val;
        case (idx)
            0:  val = 32'd536870912;
            1:  val = 32'd316933406;
            2:  val = 32'd167458907;
            3:  val = 32'd85004756;
            4:  val = 32'd42667331;
            5:  val = 32'd21354465;
            6:  val = 32'd10680862;
            7:  val = 32'd5340245;
            8:  val = 32'd2670675;
            9:  val = 32'd1335087;
            10: val = 32'd667544;
            11: val = 32'd333772;
            12: val = 32'd166886;
            13: val = 32'd83443;
            14: val = 32'd41722;
            15: val = 32'd20861;
            16: val = 32'd10430;
            17: val = 32'd5215;
            18: val = 32'd2608;
            19: val = 32'd1304;
            20: val = 32'd652;
            21: val = 32'd326;
            22: val = 32'd163;
            23: val = 32'd81;
            default: val = 32'd0;
        endcase
        return val;
    endfunction

endpackage

// ===== src/swerve_wheel_kinematics.sv =====
// swerve drive inverse kinematics: four wheel vectors, pipelined cordic, rpm and heading
// stages in order: yaw products, pre-rotation, NUM_STAGES cordic rotations, gain, scale, output
// throughput: one command per cycle, set by the fully unrolled cordic pipeline
// the whole pipeline holds while the output register is full and not taken
// rst_n clears all valid bits and loads the register defaults (200, 200, 158536)
// payload registers are not reset
module swerve_wheel_kinematics (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_addr,
    input  logic [swk_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // vel_x, vel_y, yaw_rate
    input  logic [swk_pkg::IN_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // wheel0_rpm, wheel0_heading, wheel1_rpm, wheel1_heading,
    // wheel2_rpm, wheel2_heading, wheel3_rpm, wheel3_heading, zero pad
    output logic [swk_pkg::OUT_DATA_W-1:0] m_tdata
);
    import swk_pkg::*;

    logic [LEN_W-1:0]   half_length_a_reg;
    logic [LEN_W-1:0]   half_width_b_reg;
    logic [SCALE_W-1:0] speed_scale_reg;

    logic adv;

    // stage p: yaw products
    logic                     p_vld_reg;
    logic signed [VEL_W-1:0]  p_vx_reg, p_vy_reg;
    logic signed [PROD_W-1:0] p_pa_reg, p_pb_reg;

    // cordic stages, index 0 is the pre-rotated vector
    logic        c_vld_reg [0:NUM_STAGES];
    cord_t       cx_reg    [0:NUM_STAGES][0:NUM_WHEELS-1];
    cord_t       cy_reg    [0:NUM_STAGES][0:NUM_WHEELS-1];
    logic [31:0] cz_reg    [0:NUM_STAGES][0:NUM_WHEELS-1];
    logic        cnil_reg  [0:NUM_STAGES][0:NUM_WHEELS-1];

    // stage m1: gain product, stage m2: scale product
    logic                            m1_vld_reg, m2_vld_reg;
    logic [CORD_W+GAIN_W-1:0]        m1_prod_reg [0:NUM_WHEELS-1];
    logic [MAG_W+SCALE_W-1:0]        m2_prod_reg [0:NUM_WHEELS-1];
    logic [31:0]                     m1_z_reg    [0:NUM_WHEELS-1];
    logic [31:0]                     m2_z_reg    [0:NUM_WHEELS-1];
    logic                            m1_nil_reg  [0:NUM_WHEELS-1];
    logic                            m2_nil_reg  [0:NUM_WHEELS-1];

    logic                   out_vld_reg;
    logic [OUT_DATA_W-1:0]  out_data_reg, out_data_next;

    assign adv      = !out_vld_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_length_a_reg <= LEN_W'(200);
            half_width_b_reg  <= LEN_W'(200);
            speed_scale_reg   <= SCALE_W'(158536);
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_addr))
                REG_HALF_LENGTH_A: half_length_a_reg <= cfg_data[LEN_W-1:0];
                REG_HALF_WIDTH_B:  half_width_b_reg  <= cfg_data[LEN_W-1:0];
                REG_SPEED_SCALE:   speed_scale_reg   <= cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg   <= 1'b0;
            for (int i = 0; i <= NUM_STAGES; i++)
                c_vld_reg[i] <= 1'b0;
            m1_vld_reg  <= 1'b0;
            m2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            p_vld_reg    <= s_tvalid;
            c_vld_reg[0] <= p_vld_reg;
            for (int i = 1; i <= NUM_STAGES; i++)
                c_vld_reg[i] <= c_vld_reg[i-1];
            m1_vld_reg  <= c_vld_reg[NUM_STAGES];
            m2_vld_reg  <= m1_vld_reg;
            out_vld_reg <= m2_vld_reg;
        end
    end

    // wheel vectors from the yaw products
    logic signed [ROT_W-1:0] ra, rb;
    logic signed [VEC_W-1:0] wx [0:NUM_WHEELS-1];
    logic signed [VEC_W-1:0] wy [0:NUM_WHEELS-1];
    cord_t                   sx [0:NUM_WHEELS-1];
    cord_t                   sy [0:NUM_WHEELS-1];

    always_comb
    begin
        ra = ROT_W'(p_pa_reg >>> 10);
        rb = ROT_W'(p_pb_reg >>> 10);
        for (int w = 0; w < NUM_WHEELS; w++)
        begin
            if (w < 2)
                wx[w] = VEC_W'(p_vx_reg) - VEC_W'(ra);
            else
                wx[w] = VEC_W'(p_vx_reg) + VEC_W'(ra);
            if (w == 0 || w == 3)
                wy[w] = VEC_W'(p_vy_reg) + VEC_W'(rb);
            else
                wy[w] = VEC_W'(p_vy_reg) - VEC_W'(rb);
            sx[w] = CORD_W'(wx[w]) <<< FRAC_BITS;
            sy[w] = CORD_W'(wy[w]) <<< FRAC_BITS;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_vx_reg <= s_tdata[15:0];
            p_vy_reg <= s_tdata[31:16];
            p_pa_reg <= $signed(s_tdata[47:32]) * $signed({1'b0, half_length_a_reg});
            p_pb_reg <= $signed(s_tdata[47:32]) * $signed({1'b0, half_width_b_reg});

            // left half-plane: turn by half a turn first
            for (int w = 0; w < NUM_WHEELS; w++)
            begin
                cnil_reg[0][w] <= (wx[w] == '0) && (wy[w] == '0);
                if (sx[w] < 0)
                begin
                    cx_reg[0][w] <= -sx[w];
                    cy_reg[0][w] <= -sy[w];
                    cz_reg[0][w] <= HALF_TURN;
                end
                else
                begin
                    cx_reg[0][w] <= sx[w];
                    cy_reg[0][w] <= sy[w];
                    cz_reg[0][w] <= '0;
                end
            end

            for (int i = 0; i < NUM_STAGES; i++)
            begin
                for (int w = 0; w < NUM_WHEELS; w++)
                begin
                    cnil_reg[i+1][w] <= cnil_reg[i][w];
                    if (!cy_reg[i][w][CORD_W-1])
                    begin
                        cx_reg[i+1][w] <= cx_reg[i][w] + (cy_reg[i][w] >>> i);
                        cy_reg[i+1][w] <= cy_reg[i][w] - (cx_reg[i][w] >>> i);
                        cz_reg[i+1][w] <= cz_reg[i][w] + atan_turn(i);
                    end
                    else
                    begin
                        cx_reg[i+1][w] <= cx_reg[i][w] - (cy_reg[i][w] >>> i);
                        cy_reg[i+1][w] <= cy_reg[i][w] + (cx_reg[i][w] >>> i);
                        cz_reg[i+1][w] <= cz_reg[i][w] - atan_turn(i);
                    end
                end
            end

            for (int w = 0; w < NUM_WHEELS; w++)
            begin
                // negative x after the rotations reads as zero magnitude
                if (cx_reg[NUM_STAGES][w][CORD_W-1])
                    m1_prod_reg[w] <= '0;
                else
                    m1_prod_reg[w] <= (CORD_W+GAIN_W)'(unsigned'(cx_reg[NUM_STAGES][w]))
                                      * (CORD_W+GAIN_W)'(INV_GAIN_Q16);
                m1_z_reg[w]   <= cz_reg[NUM_STAGES][w];
                m1_nil_reg[w] <= cnil_reg[NUM_STAGES][w];

                m2_prod_reg[w] <= (MAG_W+SCALE_W)'(m1_prod_reg[w][16 +: MAG_W])
                                  * (MAG_W+SCALE_W)'(speed_scale_reg);
                m2_z_reg[w]   <= m1_z_reg[w];
                m2_nil_reg[w] <= m1_nil_reg[w];
            end

            out_data_reg <= out_data_next;
        end
    end

    logic [MAG_W-1:0]  rpm_raw [0:NUM_WHEELS-1];
    logic [31:0]       z_rnd   [0:NUM_WHEELS-1];
    logic [RPM_W-1:0]  rpm     [0:NUM_WHEELS-1];
    logic [HEAD_W-1:0] head    [0:NUM_WHEELS-1];

    always_comb
    begin
        out_data_next = '0;
        for (int w = 0; w < NUM_WHEELS; w++)
        begin
            rpm_raw[w] = m2_prod_reg[w][24 +: MAG_W];
            z_rnd[w]   = m2_z_reg[w] + HEAD_ROUND;
            if (m2_nil_reg[w])
            begin
                rpm[w]  = '0;
                head[w] = '0;
            end
            else
            begin
                rpm[w]  = (rpm_raw[w] > MAG_W'(65535)) ? 16'hFFFF : rpm_raw[w][RPM_W-1:0];
                head[w] = HEAD_W'(z_rnd[w] >> (32 - ANGLE_BITS));
            end
            out_data_next[w*(RPM_W+HEAD_W) +: RPM_W]           = rpm[w];
            out_data_next[w*(RPM_W+HEAD_W) + RPM_W +: HEAD_W]  = head[w];
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stage");

    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> p_vld_reg)
        else $error("accepted beat did not enter the pipeline");

    assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(m2_vld_reg) && $stable(c_vld_reg[NUM_STAGES]) && $stable(p_vld_reg))
        else $error("pipeline moved during a stall");

endmodule

// ===== tb/sv/swk_checker.sv =====
// checker for the swerve wheel kinematics block: predicts wheel rpm and heading per command
`timescale 1ns / 100ps
module swk_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [1:0]                           cfg_addr,
    input  logic [swk_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                 s_tvalid,
    input  logic                                 s_tready,
    input  logic [swk_pkg::IN_DATA_W-1:0]        s_tdata,
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [swk_pkg::OUT_DATA_W-1:0]       m_tdata,
    output int                                   fail_count,
    output int                                   pending
);
    import swk_pkg::*;

    localparam logic [31:0] ATAN_LUT [0:23] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331, 32'd21354465, 32'd10680862, 32'd5340245,
        32'd2670675, 32'd1335087, 32'd667544, 32'd333772,
        32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304,
        32'd652, 32'd326, 32'd163, 32'd81
    };

    logic [LEN_W-1:0]   half_len;
    logic [LEN_W-1:0]   half_wid;
    logic [SCALE_W-1:0] rpm_scale;
    logic [OUT_DATA_W-1:0] wheel_q[$];

    // vectoring cordic on one wheel vector, returns {heading, rpm}
    function automatic logic [28:0] wheel_solve(longint vx, longint vy,
                                                logic [SCALE_W-1:0] scl);
        longint x;
        longint y;
        longint dx;
        longint dy;
        longint mag;
        logic [63:0] r;
        logic [31:0] z;
        logic [15:0] rpm;
        if (vx == 0 && vy == 0)
            return '0;
        x = vx * 256;
        y = vy * 256;
        z = 32'd0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = HALF_TURN;
        end
        for (int i = 0; i < NUM_STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx;
                y -= dy;
                z += ATAN_LUT[i];
            end
            else
            begin
                x -= dx;
                y += dy;
                z -= ATAN_LUT[i];
            end
        end
        if (x < 0)
            x = 0;
        mag = (x * 39797) >>> 16;
        r = (64'(mag) * 64'(scl)) >> 24;
        rpm = (r > 64'd65535) ? 16'hFFFF : r[15:0];
        z = (z + HEAD_ROUND) >> (32 - ANGLE_BITS);
        return {z[12:0], rpm};
    endfunction

    function automatic logic [OUT_DATA_W-1:0] command_solve(logic [IN_DATA_W-1:0] cmd);
        longint vx;
        longint vy;
        longint wz;
        longint ra;
        longint rb;
        logic [OUT_DATA_W-1:0] res;
        vx = longint'($signed(cmd[15:0]));
        vy = longint'($signed(cmd[31:16]));
        wz = longint'($signed(cmd[47:32]));
        ra = (wz * longint'(half_len)) >>> 10;
        rb = (wz * longint'(half_wid)) >>> 10;
        res = '0;
        res[28:0]    = wheel_solve(vx - ra, vy + rb, rpm_scale);
        res[57:29]   = wheel_solve(vx - ra, vy - rb, rpm_scale);
        res[86:58]   = wheel_solve(vx + ra, vy - rb, rpm_scale);
        res[115:87]  = wheel_solve(vx + ra, vy + rb, rpm_scale);
        return res;
    endfunction

    assign pending = wheel_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic [OUT_DATA_W-1:0] want;
        if (!rst_n)
        begin
            half_len   <= 11'd200;
            half_wid   <= 11'd200;
            rpm_scale  <= 24'd158536;
            fail_count <= 0;
            wheel_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_addr))
                    REG_HALF_LENGTH_A: half_len  <= cfg_data[LEN_W-1:0];
                    REG_HALF_WIDTH_B:  half_wid  <= cfg_data[LEN_W-1:0];
                    REG_SPEED_SCALE:   rpm_scale <= cfg_data[SCALE_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                wheel_q.push_back(command_solve(s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (wheel_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected output beat %h", m_tdata);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = wheel_q.pop_front();
                    if (want !== m_tdata)
                    begin
                        if (fail_count < 10)
                            for (int w = 0; w < NUM_WHEELS; w++)
                                $display("wheel%0d exp rpm %0d head %0d got rpm %0d head %0d",
                                    w, want[29*w +: 16], want[29*w+16 +: 13],
                                    m_tdata[29*w +: 16], m_tdata[29*w+16 +: 13]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== tb/sv/testbench.sv =====
// top of the swerve wheel kinematics testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module testbench;
    import swk_pkg::*;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_addr;
    logic [CFG_W-1:0] cfg_data;
    logic s_tvalid;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    int fail_count;
    int pending;
    bit sink_on;

    swerve_wheel_kinematics u_dut (.*);

    swk_checker u_chk (.*);

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic send_cmd(logic [15:0] vx, logic [15:0] vy, logic [15:0] wz);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {wz, vy, vx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    function automatic logic [15:0] rand_vel();
        case ($urandom_range(0, 4))
            0: return 16'($urandom_range(0, 65535));
            1: return 16'($signed($urandom_range(0, 4000)) - 2000);
            2: return 16'($urandom_range(0, 1) ? 16'h7FFF : 16'h8000);
            3: return 16'($urandom_range(0, 1) ? $urandom_range(0, 3) : -$urandom_range(0, 3));
            default: return 16'($signed($urandom_range(0, 400)) - 200);
        endcase
    endfunction

    // stall the result side at random
    always @(negedge clk)
    begin
        if (!sink_on)
            m_tready <= 1'b0;
        else if ($urandom_range(0, 99) < 6)
            m_tready <= 1'b0;
        else if ($urandom_range(0, 99) < 3)
        begin
            m_tready <= 1'b0;
            repeat ($urandom_range(10, 40)) @(negedge clk);
        end
        else
            m_tready <= 1'b1;
    end

    initial
    begin
        #20ms;
        $display("swerve_wheel_kinematics regression: fail");
        $finish;
    end

    initial
    begin
        logic [15:0] ext [0:5];
        logic [CFG_W-1:0] scales [0:3];
        logic [10:0] lens [0:3];
        ext = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001, 16'h5555};
        scales = '{24'd158536, 24'hFFFFFF, 24'd0, 24'd65536};
        lens = '{11'd200, 11'd2047, 11'd0, 11'd1024};
        rst_n    = 1'b0;
        cfg_we   = 1'b0;
        cfg_addr = 2'd0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        sink_on  = 1'b1;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: zero vector, extremes, each half plane and axis
        send_cmd(16'd0, 16'd0, 16'd0);
        for (int i = 0; i < 6; i++)
            for (int j = 0; j < 3; j++)
                send_cmd(ext[i], ext[(i + j + 1) % 6], ext[(i + 2 * j) % 6]);
        send_cmd(16'hFFF0, 16'd0, 16'd0);
        send_cmd(16'd0, 16'hFFF0, 16'd0);
        send_cmd(16'd0, 16'd16, 16'd0);
        send_cmd(16'd0, 16'd0, 16'd1024);
        drain();
        write_reg(REG_UNUSED, 24'h123456);

        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_HALF_LENGTH_A, CFG_W'(ph < 4 ? lens[ph] : $urandom_range(0, 2047)));
            write_reg(REG_HALF_WIDTH_B, CFG_W'(ph < 4 ? lens[3 - ph] : $urandom_range(0, 2047)));
            write_reg(REG_SPEED_SCALE, ph < 4 ? scales[ph] : CFG_W'($urandom_range(0, 24'hFFFFFF)));
            for (int k = 0; k < 190; k++)
                send_cmd(rand_vel(), rand_vel(), rand_vel());
            drain();
        end
        sink_on = 1'b0;

        if (fail_count == 0)
            $display("swerve_wheel_kinematics regression: pass");
        else
            $display("swerve_wheel_kinematics regression: fail");
        $finish;
    end
endmodule
